/* sv/depth_median_follow_controller_core_defines.svh */
// Assertion macros shared by the depth median follow controller RTL.
// Included by the modules that carry assertions; expects clk and rst_n in scope.
`ifndef DEPTH_MEDIAN_FOLLOW_CONTROLLER_CORE_DEFINES_SVH
`define DEPTH_MEDIAN_FOLLOW_CONTROLLER_CORE_DEFINES_SVH

// The condition holds at every clock edge out of reset.
`define DMF_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// The consequent holds in the same cycle as the antecedent.
`define DMF_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define DMF_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/dmf_pkg.sv */
// Types and constants of the depth median follow controller.
// No dependencies; every RTL module of the block refers to it by scoped names.
package dmf_pkg;

    localparam int DEPTH_W   = 14;
    localparam int NUM_W     = 27;
    localparam int DEN_W     = 14;
    localparam int CFG_IDX_W = 4;
    localparam int CFG_DAT_W = 14;

    localparam logic [15:0] DEPTH_LO_MM = 16'd100;
    localparam logic [15:0] DEPTH_HI_MM = 16'd10000;

    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 4'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_NEAR_MM      = 4'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FAR_MM       = 4'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_LINEAR   = 4'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_ROTATION = 4'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_ROT_GAIN     = 4'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_LOST     = 4'd7;

    typedef enum logic [2:0] {
        STATUS_COMMAND  = 3'd0,
        STATUS_TOO_FEW  = 3'd1,
        STATUS_NEW_LOST = 3'd2,
        STATUS_LOST     = 3'd3,
        STATUS_BAD_RECT = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SAMPLE,
        ST_DECIDE,
        ST_SHIFT,
        ST_MUL,
        ST_LAUNCH,
        ST_DIV
    } state_t;

    typedef struct packed {
        logic [12:0] image_width;
        logic [12:0] image_height;
        logic [13:0] near_mm;
        logic [13:0] far_mm;
        logic [12:0] max_linear;
        logic [13:0] max_rotation;
        logic [9:0]  rot_gain;
        logic [7:0]  max_lost;
    } cfg_regs_t;

    typedef struct packed {
        logic    accept;
        logic    sample;
        logic    load_shift;
        logic    shift;
        logic    mul;
        logic    div_start;
        logic    miss_step;
        logic    set_lost;
        logic    emit;
        status_t result;
    } dp_cmd_t;

    typedef struct packed {
        logic last;
        logic lost;
        logic bad_rect;
        logic enough;
        logic miss_limit;
        logic shift_done;
        logic div_needed;
        logic div_done;
    } dp_stat_t;

endpackage

/* sv/depth_median_follow_controller_core.sv */
// Depth median follow controller. A transaction is taken when start is high and
// busy is low. A header is taken while the block stays idle. A depth sample is
// latched, then checked and inserted into a row of sorted compare cells. The
// sample marked last closes the window and raises busy further: a failed window
// reports from the decide state; a good window walks the median down the cells,
// forms the products and, when the distance is outside the dead band, runs a
// bit-serial divider before it reports. Each result appears for one cycle with
// done high and must be taken then: the block holds nothing back for the receiver.
// Depends on dmf_pkg, dmf_controller and dmf_datapath.
module depth_median_follow_controller_core
#(
    parameter int WINDOW_RADIUS = 2,
    parameter int MIN_VALID     = 3
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic                                kind,
    input  logic signed [12:0]                  rect_x,
    input  logic signed [12:0]                  rect_y,
    input  logic signed [12:0]                  rect_w,
    input  logic signed [12:0]                  rect_h,
    input  logic                                tracker_good,
    input  logic [15:0]                         depth_mm,
    input  logic                                depth_finite,
    input  logic                                last,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [dmf_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [dmf_pkg::CFG_DAT_W-1:0]       cfg_data,
    output logic                                done,
    output logic [2:0]                          status,
    output logic signed [13:0]                  linear_speed,
    output logic signed [14:0]                  rotation_speed,
    output logic [13:0]                         distance_mm,
    output logic [4:0]                          valid_count
);

    dmf_pkg::cfg_regs_t cfg_reg;
    dmf_pkg::dp_cmd_t   cmd;
    dmf_pkg::dp_stat_t  stat;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.image_width  <= 13'd640;
            cfg_reg.image_height <= 13'd480;
            cfg_reg.near_mm      <= 14'd2500;
            cfg_reg.far_mm       <= 14'd4000;
            cfg_reg.max_linear   <= 13'd500;
            cfg_reg.max_rotation <= 14'd750;
            cfg_reg.rot_gain     <= 10'd10;
            cfg_reg.max_lost     <= 8'd10;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                dmf_pkg::CFG_IMAGE_WIDTH:  cfg_reg.image_width  <= cfg_data[12:0];
                dmf_pkg::CFG_IMAGE_HEIGHT: cfg_reg.image_height <= cfg_data[12:0];
                dmf_pkg::CFG_NEAR_MM:      cfg_reg.near_mm      <= cfg_data;
                dmf_pkg::CFG_FAR_MM:       cfg_reg.far_mm       <= cfg_data;
                dmf_pkg::CFG_MAX_LINEAR:   cfg_reg.max_linear   <= cfg_data[12:0];
                dmf_pkg::CFG_MAX_ROTATION: cfg_reg.max_rotation <= cfg_data;
                dmf_pkg::CFG_ROT_GAIN:     cfg_reg.rot_gain     <= cfg_data[9:0];
                dmf_pkg::CFG_MAX_LOST:     cfg_reg.max_lost     <= cfg_data[7:0];
                default:
                begin
                    // Writes beyond the register list are dropped.
                end
            endcase
        end
    end

    dmf_controller u_ctrl
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .kind  (kind),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy)
    );

    dmf_datapath
    #(
        .WINDOW_RADIUS (WINDOW_RADIUS),
        .MIN_VALID     (MIN_VALID)
    )
    u_dp
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .stat           (stat),
        .cfg            (cfg_reg),
        .kind           (kind),
        .rect_x         (rect_x),
        .rect_y         (rect_y),
        .rect_w         (rect_w),
        .rect_h         (rect_h),
        .tracker_good   (tracker_good),
        .depth_mm       (depth_mm),
        .depth_finite   (depth_finite),
        .last           (last),
        .done           (done),
        .status         (status),
        .linear_speed   (linear_speed),
        .rotation_speed (rotation_speed),
        .distance_mm    (distance_mm),
        .valid_count    (valid_count)
    );

endmodule

/* sv/dmf_divider.sv */
// Restoring divider, one quotient bit per cycle, for the linear speed scaling.
// Depends on dmf_pkg for the operand widths.
module dmf_divider
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [dmf_pkg::NUM_W-1:0]   numer,
    input  logic [dmf_pkg::DEN_W-1:0]   denom,
    output logic                        done,
    output logic [dmf_pkg::NUM_W-1:0]   quotient
);

    localparam int NW = dmf_pkg::NUM_W;
    localparam int DW = dmf_pkg::DEN_W;
    localparam int CNT_W = $clog2(NW + 1);

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [DW-1:0]    rem_reg;
    logic [NW-1:0]    quo_reg;
    logic [DW-1:0]    den_reg;

    logic [DW:0]      trial;
    logic [DW:0]      diff;
    logic             qbit;
    logic [DW-1:0]    rem_next;

    always_comb
    begin
        trial    = {rem_reg, quo_reg[NW-1]};
        diff     = trial - {1'b0, den_reg};
        qbit     = (trial >= {1'b0, den_reg});
        rem_next = qbit ? diff[DW-1:0] : trial[DW-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(NW - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= numer;
            den_reg <= denom;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            quo_reg <= {quo_reg[NW-2:0], qbit};
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

/* sv/dmf_datapath.sv */
// Datapath: window geometry, sorted depth cells, miss tracking, speed arithmetic
// and result registers. Depends on dmf_pkg, dmf_divider and the assertion header.
`include "depth_median_follow_controller_core_defines.svh"

module dmf_datapath
#(
    parameter int WINDOW_RADIUS = 2,
    parameter int MIN_VALID     = 3
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  dmf_pkg::dp_cmd_t          cmd,
    output dmf_pkg::dp_stat_t         stat,
    input  dmf_pkg::cfg_regs_t        cfg,
    input  logic                      kind,
    input  logic signed [12:0]        rect_x,
    input  logic signed [12:0]        rect_y,
    input  logic signed [12:0]        rect_w,
    input  logic signed [12:0]        rect_h,
    input  logic                      tracker_good,
    input  logic [15:0]               depth_mm,
    input  logic                      depth_finite,
    input  logic                      last,
    output logic                      done,
    output logic [2:0]                status,
    output logic signed [13:0]        linear_speed,
    output logic signed [14:0]        rotation_speed,
    output logic [13:0]               distance_mm,
    output logic [4:0]                valid_count
);

    localparam int SIDE  = 2 * WINDOW_RADIUS + 1;
    localparam int WIN_N = SIDE * SIDE;
    localparam int CW    = $clog2(WIN_N + 1);
    localparam int PW    = $clog2(SIDE + 1);
    localparam int DW    = dmf_pkg::DEPTH_W;

    // Latched sample.
    logic [15:0]         depth_reg;
    logic                finite_reg;
    logic                last_reg;

    // Window rectangle and its center.
    logic signed [12:0]  x_reg, y_reg, w_reg, h_reg;
    logic signed [13:0]  cx_reg, cy_reg;
    logic [PW-1:0]       col_reg, row_reg;
    logic [CW-1:0]       count_reg;
    logic [CW-1:0]       shift_cnt_reg;
    logic [7:0]          miss_reg;
    logic                lost_reg;

    // Sorted depth cells; entries at or above count_reg are stale.
    logic [DW-1:0]       cell_reg  [WIN_N];
    logic [DW-1:0]       cell_next [WIN_N];
    logic                gt        [WIN_N];

    // Speed arithmetic stage.
    logic [DW-1:0]       d_reg;
    logic                neg_reg, far_reg, need_div_reg;
    logic [dmf_pkg::NUM_W-1:0] prod_reg;
    logic [dmf_pkg::DEN_W-1:0] den_reg;
    logic signed [26:0]  rotp_reg;

    // Result registers.
    logic                done_reg;
    dmf_pkg::status_t    status_reg;
    logic signed [13:0]  lin_reg;
    logic signed [14:0]  rot_reg;
    logic [13:0]         dist_reg;
    logic [4:0]          vcount_reg;

    logic                div_done;
    logic [dmf_pkg::NUM_W-1:0] quotient;

    // Header center: x + w/2 with the halving truncated toward zero.
    logic [13:0]         wx_plus, hy_plus;
    logic [13:0]         cx_in, cy_in;

    always_comb
    begin
        wx_plus = {rect_w[12], rect_w} + {13'd0, rect_w[12]};
        hy_plus = {rect_h[12], rect_h} + {13'd0, rect_h[12]};
        cx_in   = {rect_x[12], rect_x} + {wx_plus[13], wx_plus[13:1]};
        cy_in   = {rect_y[12], rect_y} + {hy_plus[13], hy_plus[13:1]};
    end

    // Sample acceptance.
    logic [15:0] px, py;
    logic        in_window, pix_ok, depth_ok, do_insert;
    logic [DW-1:0] dnew;

    always_comb
    begin
        px = {{2{cx_reg[13]}}, cx_reg} + 16'(col_reg) - 16'(WINDOW_RADIUS);
        py = {{2{cy_reg[13]}}, cy_reg} + 16'(row_reg) - 16'(WINDOW_RADIUS);
        in_window = (row_reg < PW'(SIDE));
        pix_ok = !px[15] && (px[14:0] < {2'b00, cfg.image_width})
              && !py[15] && (py[14:0] < {2'b00, cfg.image_height});
        depth_ok = finite_reg && (depth_reg > dmf_pkg::DEPTH_LO_MM)
                && (depth_reg < dmf_pkg::DEPTH_HI_MM);
        do_insert = cmd.sample && in_window && pix_ok && depth_ok
                 && (count_reg < CW'(WIN_N));
        dnew = depth_reg[DW-1:0];
    end

    // Each cell compares against the new depth and takes it, takes its lower
    // neighbor, or holds; a shift moves every cell but the last one place toward cell 0.
    always_comb
    begin
        for (int i = 0; i < WIN_N; i++)
        begin
            gt[i] = (CW'(i) < count_reg) && (cell_reg[i] > dnew);
        end
        for (int i = 0; i < WIN_N; i++)
        begin
            cell_next[i] = cell_reg[i];
        end
        if (do_insert)
        begin
            if (gt[0] || (count_reg == '0))
            begin
                cell_next[0] = dnew;
            end
            for (int i = 1; i < WIN_N; i++)
            begin
                if (gt[i-1])
                begin
                    cell_next[i] = cell_reg[i-1];
                end
                else if (gt[i] || (CW'(i) == count_reg))
                begin
                    cell_next[i] = dnew;
                end
            end
        end
        else if (cmd.shift)
        begin
            for (int i = 0; i < WIN_N - 1; i++)
            begin
                cell_next[i] = cell_reg[i+1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < WIN_N; i++)
        begin
            cell_reg[i] <= cell_next[i];
        end
    end

    // Rectangle check against the image size.
    logic signed [14:0] xw, yh, wlim, hlim;
    logic               bad_rect;

    always_comb
    begin
        xw   = {{2{x_reg[12]}}, x_reg} + {{2{w_reg[12]}}, w_reg};
        yh   = {{2{y_reg[12]}}, y_reg} + {{2{h_reg[12]}}, h_reg};
        wlim = {2'b00, cfg.image_width};
        hlim = {2'b00, cfg.image_height};
        bad_rect = w_reg[12] || (w_reg == 13'sd0) || h_reg[12] || (h_reg == 13'sd0)
                || x_reg[12] || y_reg[12] || (xw > wlim) || (yh > hlim);
    end

    // Window state and miss tracking.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_reg         <= '0;
            y_reg         <= '0;
            w_reg         <= '0;
            h_reg         <= '0;
            cx_reg        <= '0;
            cy_reg        <= '0;
            col_reg       <= '0;
            row_reg       <= '0;
            count_reg     <= '0;
            shift_cnt_reg <= '0;
            miss_reg      <= '0;
            lost_reg      <= 1'b0;
        end
        else
        begin
            if (cmd.accept && !kind)
            begin
                x_reg     <= rect_x;
                y_reg     <= rect_y;
                w_reg     <= rect_w;
                h_reg     <= rect_h;
                cx_reg    <= cx_in;
                cy_reg    <= cy_in;
                col_reg   <= '0;
                row_reg   <= '0;
                count_reg <= '0;
                if (tracker_good)
                begin
                    miss_reg <= '0;
                    lost_reg <= 1'b0;
                end
            end
            if (cmd.sample && in_window)
            begin
                if (col_reg == PW'(SIDE - 1))
                begin
                    col_reg <= '0;
                    row_reg <= row_reg + 1'b1;
                end
                else
                begin
                    col_reg <= col_reg + 1'b1;
                end
            end
            if (do_insert)
            begin
                count_reg <= count_reg + 1'b1;
            end
            if (cmd.load_shift)
            begin
                shift_cnt_reg <= count_reg >> 1;
            end
            else if (cmd.shift)
            begin
                shift_cnt_reg <= shift_cnt_reg - 1'b1;
            end
            if (cmd.miss_step && (miss_reg != 8'hFF))
            begin
                miss_reg <= miss_reg + 1'b1;
            end
            if (cmd.set_lost)
            begin
                lost_reg <= 1'b1;
            end
            if (cmd.emit)
            begin
                col_reg   <= '0;
                row_reg   <= '0;
                count_reg <= '0;
            end
        end
    end

    // Sample latch and arithmetic operands; payload only.
    logic [DW-1:0]      d_med;
    logic               neg_in, far_in;
    logic [13:0]        lin_diff;
    logic signed [15:0] rot_err;

    always_comb
    begin
        d_med    = cell_reg[0];
        neg_in   = (d_med < cfg.near_mm);
        far_in   = !neg_in && (d_med > cfg.far_mm);
        lin_diff = neg_in ? (cfg.near_mm - d_med) : (d_med - cfg.far_mm);
        rot_err  = {{2{x_reg[12]}}, x_reg, 1'b0} + {{3{w_reg[12]}}, w_reg}
                 - {3'b000, cfg.image_width};
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept && kind)
        begin
            depth_reg  <= depth_mm;
            finite_reg <= depth_finite;
            last_reg   <= last;
        end
        if (cmd.mul)
        begin
            d_reg        <= d_med;
            neg_reg      <= neg_in;
            far_reg      <= far_in;
            need_div_reg <= neg_in || (far_in && (cfg.far_mm != '0));
            prod_reg     <= {14'd0, cfg.max_linear} * {13'd0, lin_diff};
            den_reg      <= neg_in ? cfg.near_mm : cfg.far_mm;
            rotp_reg     <= 27'(rot_err) * 27'($signed({1'b0, cfg.rot_gain}));
        end
    end

    dmf_divider u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .numer    (prod_reg),
        .denom    (den_reg),
        .done     (div_done),
        .quotient (quotient)
    );

    // Final scaling and clamps.
    logic [dmf_pkg::NUM_W-1:0] mag_full;
    logic [12:0]               mag;
    logic signed [13:0]        lin_val;
    logic signed [27:0]        rot_ext, rot_half, rot_neg, rot_max, rot_val;

    always_comb
    begin
        if (need_div_reg)
        begin
            mag_full = quotient;
        end
        else if (far_reg)
        begin
            mag_full = {14'd0, cfg.max_linear};
        end
        else
        begin
            mag_full = '0;
        end
        mag     = (mag_full > {14'd0, cfg.max_linear}) ? cfg.max_linear : mag_full[12:0];
        lin_val = neg_reg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});

        rot_ext  = {rotp_reg[26], rotp_reg};
        rot_half = rot_ext[27] ? ((rot_ext + 28'sd1) >>> 1) : (rot_ext >>> 1);
        rot_neg  = -rot_half;
        rot_max  = $signed({14'd0, cfg.max_rotation});
        if (rot_neg > rot_max)
        begin
            rot_val = rot_max;
        end
        else if (rot_neg < -rot_max)
        begin
            rot_val = -rot_max;
        end
        else
        begin
            rot_val = rot_neg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= cmd.emit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            status_reg <= cmd.result;
            unique case (cmd.result)
                dmf_pkg::STATUS_COMMAND:
                begin
                    lin_reg    <= lin_val;
                    rot_reg    <= rot_val[14:0];
                    dist_reg   <= d_reg;
                    vcount_reg <= 5'(count_reg);
                end
                dmf_pkg::STATUS_TOO_FEW, dmf_pkg::STATUS_NEW_LOST:
                begin
                    lin_reg    <= '0;
                    rot_reg    <= '0;
                    dist_reg   <= '0;
                    vcount_reg <= 5'(count_reg);
                end
                default:
                begin
                    lin_reg    <= '0;
                    rot_reg    <= '0;
                    dist_reg   <= '0;
                    vcount_reg <= '0;
                end
            endcase
        end
    end

    always_comb
    begin
        stat.last       = last_reg;
        stat.lost       = lost_reg;
        stat.bad_rect   = bad_rect;
        stat.enough     = (int'(count_reg) >= MIN_VALID);
        stat.miss_limit = (miss_reg >= cfg.max_lost);
        stat.shift_done = (shift_cnt_reg == '0);
        stat.div_needed = need_div_reg;
        stat.div_done   = div_done;
    end

    assign done           = done_reg;
    assign status         = status_reg;
    assign linear_speed   = lin_reg;
    assign rotation_speed = rot_reg;
    assign distance_mm    = dist_reg;
    assign valid_count    = vcount_reg;

    `DMF_ASSERT_NEXT(a_done_single, done_reg, !done_reg, "result strobe held for two cycles")
    `DMF_ASSERT_IMPL(a_div_den, cmd.div_start, den_reg != '0, "division started by zero")
    `DMF_ASSERT_IMPL(a_quiet_fields, done_reg && (status_reg != dmf_pkg::STATUS_COMMAND),
        (lin_reg == '0) && (rot_reg == '0) && (dist_reg == '0), "speed set without command")
    `DMF_ASSERT_ALWAYS(a_count_range, int'(count_reg) <= WIN_N, "window count overflow")

endmodule

/* sv/dmf_controller.sv */
// Sequencing state machine of the depth median follow controller.
// Depends on dmf_pkg; drives the datapath through dp_cmd_t and reads dp_stat_t.
module dmf_controller
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic               kind,
    input  dmf_pkg::dp_stat_t  stat,
    output dmf_pkg::dp_cmd_t   cmd,
    output logic               busy
);

    dmf_pkg::state_t state_reg;
    dmf_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= dmf_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.result = dmf_pkg::STATUS_COMMAND;
        unique case (state_reg)
            dmf_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    cmd.accept = 1'b1;
                    if (kind)
                    begin
                        state_next = dmf_pkg::ST_SAMPLE;
                    end
                end
            end
            dmf_pkg::ST_SAMPLE:
            begin
                cmd.sample = 1'b1;
                state_next = stat.last ? dmf_pkg::ST_DECIDE : dmf_pkg::ST_IDLE;
            end
            dmf_pkg::ST_DECIDE:
            begin
                if (stat.lost)
                begin
                    cmd.emit   = 1'b1;
                    cmd.result = dmf_pkg::STATUS_LOST;
                    state_next = dmf_pkg::ST_IDLE;
                end
                else if (stat.bad_rect)
                begin
                    cmd.emit   = 1'b1;
                    cmd.result = dmf_pkg::STATUS_BAD_RECT;
                    state_next = dmf_pkg::ST_IDLE;
                end
                else if (stat.enough)
                begin
                    cmd.load_shift = 1'b1;
                    state_next     = dmf_pkg::ST_SHIFT;
                end
                else
                begin
                    cmd.miss_step = 1'b1;
                    cmd.emit      = 1'b1;
                    if (stat.miss_limit)
                    begin
                        cmd.set_lost = 1'b1;
                        cmd.result   = dmf_pkg::STATUS_NEW_LOST;
                    end
                    else
                    begin
                        cmd.result = dmf_pkg::STATUS_TOO_FEW;
                    end
                    state_next = dmf_pkg::ST_IDLE;
                end
            end
            dmf_pkg::ST_SHIFT:
            begin
                // The median walks down to cell 0 one place per cycle.
                if (stat.shift_done)
                begin
                    state_next = dmf_pkg::ST_MUL;
                end
                else
                begin
                    cmd.shift = 1'b1;
                end
            end
            dmf_pkg::ST_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = dmf_pkg::ST_LAUNCH;
            end
            dmf_pkg::ST_LAUNCH:
            begin
                if (stat.div_needed)
                begin
                    cmd.div_start = 1'b1;
                    state_next    = dmf_pkg::ST_DIV;
                end
                else
                begin
                    cmd.emit   = 1'b1;
                    state_next = dmf_pkg::ST_IDLE;
                end
            end
            dmf_pkg::ST_DIV:
            begin
                if (stat.div_done)
                begin
                    cmd.emit   = 1'b1;
                    state_next = dmf_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = dmf_pkg::ST_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != dmf_pkg::ST_IDLE);

endmodule
